FILE: hdl/mtmc_pkg.sv
// Shared types, constants and a helper function for the tempo map converter.
`default_nettype none
package mtmc_pkg;

   localparam int TEMPO_ENTRIES = 16;
   localparam int COUNT_W       = $clog2(TEMPO_ENTRIES + 1);
   localparam int OPCODE_W      = 2;
   localparam int TICK_W        = 32;
   localparam int TEMPO_W       = 24;
   localparam int TIME_W        = 40;
   localparam int TPQ_W         = 15;
   localparam int PROD_W        = TICK_W + TEMPO_W;
   localparam int DIV_STEPS     = TEMPO_W;
   localparam int WALK_CYCLES   = TEMPO_ENTRIES + 1;
   localparam int STEP_W        = $clog2(DIV_STEPS + WALK_CYCLES + 1);

   localparam logic [TIME_W-1:0]  TIME_MAX     = {TIME_W{1'b1}};
   localparam logic [TEMPO_W-1:0] DEFAULT_BEAT = TEMPO_W'(500000);
   localparam logic [TPQ_W-1:0]   TPQ_RESET    = TPQ_W'(480);

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND  = 2'd0,
      OP_TO_TIME = 2'd1,
      OP_BEAT    = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Walk token handed from cell to cell.
   typedef struct packed {
      logic                tick_stop;
      logic                beat_stop;
      logic [TICK_W-1:0]   tick;
      logic [TIME_W-1:0]   qtime;
      logic [TIME_W-1:0]   total;
      logic [PROD_W-1:0]   prod;
      logic [TEMPO_W-1:0]  beat;
   } token_type;

   typedef struct packed {
      logic [TICK_W-1:0]  tick;
      logic [TIME_W-1:0]  start_time;
      logic [TEMPO_W-1:0] beat;
   } entry_type;

   typedef struct packed {
      logic             div_start;
      logic             div_step;
      logic [TPQ_W-1:0] divisor;
   } cell_cmd_type;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] total,
                                                 input logic [PROD_W-1:0] prod);
      logic [PROD_W:0] sum;
      sum = (PROD_W + 1)'(total) + (PROD_W + 1)'(prod);
      return (sum > (PROD_W + 1)'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: hdl/mtmc_if.sv
// Channel interfaces for request, response and configuration traffic.
`default_nettype none
interface mtmc_req_if;
   logic                              valid;
   logic                              ready;
   logic [mtmc_pkg::OPCODE_W-1:0]     opcode;
   logic [mtmc_pkg::TICK_W-1:0]       tick;
   logic [mtmc_pkg::TEMPO_W-1:0]      tempo_us;
   logic [mtmc_pkg::TIME_W-1:0]       query_time_us;
   modport source (output valid, opcode, tick, tempo_us, query_time_us, input ready);
   modport sink   (input valid, opcode, tick, tempo_us, query_time_us, output ready);
endinterface

interface mtmc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mtmc_pkg::TIME_W-1:0]       result_time_us;
   logic [mtmc_pkg::TEMPO_W-1:0]      beat_length_us;
   logic                              table_full;
   modport source (output valid, result_time_us, beat_length_us, table_full, input ready);
   modport sink   (input valid, result_time_us, beat_length_us, table_full, output ready);
endinterface

interface mtmc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mtmc_pkg::TPQ_W-1:0]        ticks_per_quarter;
   modport source (output valid, ticks_per_quarter, input ready);
   modport sink   (input valid, ticks_per_quarter, output ready);
endinterface
`default_nettype wire

FILE: hdl/mtmc_cell.sv
// One tempo map entry with its own serial divider and one step of the walk.
`default_nettype none
module mtmc_cell (
   input  wire logic                          clock,
   input  wire mtmc_pkg::cell_cmd_type        cmd,
   input  wire logic                          wr_en,
   input  wire mtmc_pkg::entry_type           wr_entry,
   input  wire logic                          valid,
   input  wire logic                          next_valid,
   input  wire logic [mtmc_pkg::TICK_W-1:0]   next_tick,
   output      logic [mtmc_pkg::TICK_W-1:0]   own_tick,
   input  wire mtmc_pkg::token_type           tok_in,
   output      mtmc_pkg::token_type           tok_out
);

   mtmc_pkg::entry_type                entry_ff;
   logic [mtmc_pkg::TPQ_W-1:0]         rem_ff;
   logic [mtmc_pkg::TPQ_W-1:0]         rem_in;
   logic [mtmc_pkg::TEMPO_W-1:0]       quo_ff;
   logic [mtmc_pkg::TEMPO_W-1:0]       quo_in;
   logic [mtmc_pkg::TPQ_W:0]           trial;
   logic [mtmc_pkg::TPQ_W:0]           diff;
   logic                               fits;
   logic                               tick_go;
   logic                               beat_go;
   logic                               in_span;
   logic [mtmc_pkg::TICK_W-1:0]        span;
   mtmc_pkg::token_type                tok_ff;
   mtmc_pkg::token_type                tok_next_in;

   assign own_tick = entry_ff.tick;

   // Restoring division of the beat length by the division, one bit a cycle while div_step is set.
   always_comb begin
      trial  = {rem_ff, quo_ff[mtmc_pkg::TEMPO_W-1]};
      diff   = trial - {1'b0, cmd.divisor};
      fits   = (trial >= {1'b0, cmd.divisor});
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = entry_ff.beat;
      end else if (cmd.div_step) begin
         rem_in = fits ? diff[mtmc_pkg::TPQ_W-1:0] : trial[mtmc_pkg::TPQ_W-1:0];
         quo_in = {quo_ff[mtmc_pkg::TEMPO_W-2:0], fits};
      end
   end

   always_comb begin
      tick_go = valid && !tok_in.tick_stop && (entry_ff.tick <= tok_in.tick);
      in_span = !next_valid || (tok_in.tick < next_tick);
      span    = (in_span ? tok_in.tick : next_tick) - entry_ff.tick;
      beat_go = valid && !tok_in.beat_stop && (entry_ff.start_time <= tok_in.qtime);

      tok_next_in           = tok_in;
      tok_next_in.tick_stop = !tick_go;
      tok_next_in.beat_stop = !beat_go;
      tok_next_in.total     = mtmc_pkg::sat_add(tok_in.total, tok_in.prod);
      tok_next_in.prod      = tick_go ? (mtmc_pkg::PROD_W'(span) * mtmc_pkg::PROD_W'(quo_ff))
                                      : '0;
      tok_next_in.beat      = beat_go ? entry_ff.beat : tok_in.beat;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      tok_ff <= tok_next_in;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

FILE: hdl/midi_tempo_map_converter_core.sv
// Top level of the MIDI tempo map converter: control, cell row and result register.
//
// Usage: a request beat on req_port carries an opcode, a tick, a beat length and a
// query time. Opcode append adds a tempo change whose start time is converted from
// its tick, tick to time returns microseconds, beat query returns the beat length in
// force at a time, and clear empties the map. Every request yields exactly one
// response beat on rsp_port. The user must write the division through csr_port only
// while idle; the block does not enforce it.
//
// Each map entry sits in a cell of a row. A request first runs every cell's serial
// divider, then a token walks the row one cell per cycle, and a final step loads the
// result register. The steps are the same whatever the number of entries, and the
// next request can be accepted in the same cycle as the response turns valid. A new
// request is accepted as soon as the previous result sits in the result register,
// even while the receiver stalls it. If the result register is still full when the
// next result is done, the block waits in its final step until it drains.
// Reset empties the map, sets the division to 480 and clears the response valid flag.
`default_nettype none
module midi_tempo_map_converter_core (
   input  wire logic     clock,
   input  wire logic     reset,
   mtmc_req_if.sink      req_port,
   mtmc_rsp_if.source    rsp_port,
   mtmc_csr_if.sink      csr_port
);

   mtmc_pkg::state_type                  state_ff;
   mtmc_pkg::state_type                  state_in;
   logic [mtmc_pkg::STEP_W-1:0]          step_ff;
   logic [mtmc_pkg::STEP_W-1:0]          step_in;
   logic [mtmc_pkg::TPQ_W-1:0]           tpq_ff;
   logic [mtmc_pkg::COUNT_W-1:0]         count_ff;
   logic [mtmc_pkg::COUNT_W-1:0]         count_in;

   mtmc_pkg::op_type                     op_ff;
   logic [mtmc_pkg::TICK_W-1:0]          tick_ff;
   logic [mtmc_pkg::TEMPO_W-1:0]         tempo_ff;
   logic [mtmc_pkg::TIME_W-1:0]          qtime_ff;

   logic                                 rsp_valid_ff;
   logic [mtmc_pkg::TIME_W-1:0]          rsp_time_ff;
   logic [mtmc_pkg::TEMPO_W-1:0]         rsp_beat_ff;
   logic                                 rsp_full_ff;

   logic                                 accept;
   logic                                 finish_fire;
   logic                                 div_step;
   logic                                 full;
   logic                                 do_write;
   logic [mtmc_pkg::TIME_W-1:0]          walk_total;

   mtmc_pkg::cell_cmd_type               cmd;
   mtmc_pkg::entry_type                  wr_entry;
   mtmc_pkg::token_type                  chain_tok [mtmc_pkg::TEMPO_ENTRIES+1];
   logic [mtmc_pkg::TICK_W-1:0]          cell_tick [mtmc_pkg::TEMPO_ENTRIES];
   logic [mtmc_pkg::TEMPO_ENTRIES-1:0]   cell_valid;
   logic [mtmc_pkg::TEMPO_ENTRIES-1:0]   cell_wr;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtmc_pkg::ST_IDLE: begin
            if (req_port.valid) begin
               state_in = mtmc_pkg::ST_DIVIDE;
            end
         end
         mtmc_pkg::ST_DIVIDE: begin
            if (step_ff == mtmc_pkg::STEP_W'(mtmc_pkg::DIV_STEPS - 1)) begin
               state_in = mtmc_pkg::ST_WALK;
            end
         end
         mtmc_pkg::ST_WALK: begin
            if (step_ff == mtmc_pkg::STEP_W'(mtmc_pkg::WALK_CYCLES - 1)) begin
               state_in = mtmc_pkg::ST_FINISH;
            end
         end
         mtmc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               state_in = mtmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mtmc_pkg::ST_IDLE;
         end
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_port.ready = 1'b0;
      div_step       = 1'b0;
      finish_fire    = 1'b0;
      case (state_ff)
         mtmc_pkg::ST_IDLE: begin
            req_port.ready = 1'b1;
         end
         mtmc_pkg::ST_DIVIDE: begin
            div_step = 1'b1;
         end
         mtmc_pkg::ST_WALK: begin
         end
         mtmc_pkg::ST_FINISH: begin
            finish_fire = !rsp_valid_ff || rsp_port.ready;
         end
         default: begin
         end
      endcase
   end

   assign accept = req_port.valid && req_port.ready;

   always_comb begin
      step_in = step_ff + mtmc_pkg::STEP_W'(1);
      if (state_in != state_ff) begin
         step_in = '0;
      end
   end

   assign csr_port.ready = 1'b1;

   assign full     = (op_ff == mtmc_pkg::OP_APPEND) &&
                     (count_ff == mtmc_pkg::COUNT_W'(mtmc_pkg::TEMPO_ENTRIES));
   assign do_write = finish_fire && (op_ff == mtmc_pkg::OP_APPEND) && !full;

   always_comb begin
      count_in = count_ff;
      if (do_write) begin
         count_in = count_ff + mtmc_pkg::COUNT_W'(1);
      end else if (finish_fire && (op_ff == mtmc_pkg::OP_CLEAR)) begin
         count_in = '0;
      end
   end

   assign cmd.div_start = accept;
   assign cmd.div_step  = div_step;
   assign cmd.divisor   = (tpq_ff == '0) ? mtmc_pkg::TPQ_W'(1) : tpq_ff;

   assign walk_total = mtmc_pkg::sat_add(chain_tok[mtmc_pkg::TEMPO_ENTRIES].total,
                                         chain_tok[mtmc_pkg::TEMPO_ENTRIES].prod);

   assign wr_entry.tick       = tick_ff;
   assign wr_entry.start_time = walk_total;
   assign wr_entry.beat       = tempo_ff;

   always_comb begin
      chain_tok[0].tick_stop = 1'b0;
      chain_tok[0].beat_stop = 1'b0;
      chain_tok[0].tick      = tick_ff;
      chain_tok[0].qtime     = qtime_ff;
      chain_tok[0].total     = '0;
      chain_tok[0].prod      = '0;
      chain_tok[0].beat      = mtmc_pkg::DEFAULT_BEAT;
   end

   for (genvar i = 0; i < mtmc_pkg::TEMPO_ENTRIES; i++) begin : g_cell
      logic                        nxt_valid;
      logic [mtmc_pkg::TICK_W-1:0] nxt_tick;

      assign cell_valid[i] = (count_ff > mtmc_pkg::COUNT_W'(i));
      assign cell_wr[i]    = do_write && (count_ff == mtmc_pkg::COUNT_W'(i));

      if (i == mtmc_pkg::TEMPO_ENTRIES - 1) begin : g_last
         assign nxt_valid = 1'b0;
         assign nxt_tick  = '0;
      end else begin : g_mid
         assign nxt_valid = cell_valid[i+1];
         assign nxt_tick  = cell_tick[i+1];
      end

      mtmc_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .wr_en      (cell_wr[i]),
         .wr_entry   (wr_entry),
         .valid      (cell_valid[i]),
         .next_valid (nxt_valid),
         .next_tick  (nxt_tick),
         .own_tick   (cell_tick[i]),
         .tok_in     (chain_tok[i]),
         .tok_out    (chain_tok[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtmc_pkg::ST_IDLE;
         step_ff      <= '0;
         tpq_ff       <= mtmc_pkg::TPQ_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         if (csr_port.valid && csr_port.ready) begin
            tpq_ff <= csr_port.ticks_per_quarter;
         end
         if (finish_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= mtmc_pkg::op_type'(req_port.opcode);
         tick_ff  <= req_port.tick;
         tempo_ff <= req_port.tempo_us;
         qtime_ff <= req_port.query_time_us;
      end
      if (finish_fire) begin
         rsp_time_ff <= (op_ff == mtmc_pkg::OP_TO_TIME) ? walk_total : '0;
         rsp_beat_ff <= (op_ff == mtmc_pkg::OP_BEAT)
                        ? chain_tok[mtmc_pkg::TEMPO_ENTRIES].beat : '0;
         rsp_full_ff <= full;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.result_time_us = rsp_time_ff;
   assign rsp_port.beat_length_us = rsp_beat_ff;
   assign rsp_port.table_full     = rsp_full_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= mtmc_pkg::COUNT_W'(mtmc_pkg::TEMPO_ENTRIES))
      else $error("Tempo map count exceeds the number of entries.");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == mtmc_pkg::ST_DIVIDE) && (step_ff == '0))
      else $error("Accepted request did not start the divide phase.");

   assert property (@(posedge clock) disable iff (reset)
      (finish_fire && (op_ff == mtmc_pkg::OP_CLEAR)) |=> (count_ff == '0) && rsp_valid_ff)
      else $error("Clear did not empty the map.");

   assert property (@(posedge clock) disable iff (reset)
      (finish_fire && full) |=> $stable(count_ff) && rsp_port.table_full)
      else $error("Dropped append changed the map.");

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the MIDI tempo map converter core.
module testbench;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int HOLD_CYCLES   = 300;
   localparam int REP_TICK_STEP = 7;
   localparam int PLAN_ROWS     = 21;

   typedef enum logic {ROW_REQUEST, ROW_DIVISION} row_kind_type;

   typedef struct packed {
      logic [mtmc_pkg::TIME_W-1:0]  time_us;
      logic [mtmc_pkg::TEMPO_W-1:0] beat_us;
      logic                         full;
   } map_answer_type;

   typedef struct packed {
      row_kind_type                 kind;
      mtmc_pkg::op_type             op;
      logic [mtmc_pkg::TICK_W-1:0]  tick;
      logic [mtmc_pkg::TEMPO_W-1:0] tempo;
      logic [mtmc_pkg::TIME_W-1:0]  qtime;
      logic [mtmc_pkg::TPQ_W-1:0]   division;
      logic [4:0]                   reps;
      logic                         typed;
      logic [mtmc_pkg::TIME_W-1:0]  want_time;
      logic [mtmc_pkg::TEMPO_W-1:0] want_beat;
      logic                         want_full;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{ROW_REQUEST, mtmc_pkg::OP_TO_TIME, 32'hFFFF_FFFF, 24'h0, 40'h0, 15'h0, 5'd1, 1'b1,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_BEAT, 32'h0, 24'h0, 40'hFF_FFFF_FFFF, 15'h0, 5'd1, 1'b1,
        40'h0, 24'd500000, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_CLEAR, 32'hFFFF_FFFF, 24'hFF_FFFF, 40'hFF_FFFF_FFFF, 15'h0,
        5'd1, 1'b1, 40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_APPEND, 32'd100, 24'd480000, 40'h0, 15'h0, 5'd1, 1'b1,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_TO_TIME, 32'd99, 24'h0, 40'h0, 15'h0, 5'd1, 1'b1,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_APPEND, 32'hFFFF_FFFF, 24'hFF_FFFF, 40'h0, 15'h0, 5'd1, 1'b1,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_TO_TIME, 32'hFFFF_FFFF, 24'h0, 40'h0, 15'h0, 5'd1, 1'b0,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_APPEND, 32'h0, 24'h0, 40'h0, 15'h0, 5'd1, 1'b1,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_TO_TIME, 32'h8000_0000, 24'h0, 40'h0, 15'h0, 5'd1, 1'b0,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_BEAT, 32'h0, 24'h0, 40'h0, 15'h0, 5'd1, 1'b0,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_APPEND, 32'd5000, 24'd1, 40'h0, 15'h0, 5'd13, 1'b0,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_APPEND, 32'd1, 24'd1, 40'h0, 15'h0, 5'd1, 1'b1,
        40'h0, 24'h0, 1'b1},
      '{ROW_REQUEST, mtmc_pkg::OP_BEAT, 32'h0, 24'h0, 40'hFF_FFFF_FFFF, 15'h0, 5'd1, 1'b0,
        40'h0, 24'h0, 1'b0},
      '{ROW_DIVISION, mtmc_pkg::OP_APPEND, 32'h0, 24'h0, 40'h0, 15'h0, 5'd1, 1'b0,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_TO_TIME, 32'hFFFF_FFFF, 24'h0, 40'h0, 15'h0, 5'd1, 1'b0,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_CLEAR, 32'h0, 24'h0, 40'h0, 15'h0, 5'd1, 1'b1,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_APPEND, 32'h0, 24'hFF_FFFF, 40'h0, 15'h0, 5'd1, 1'b1,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_TO_TIME, 32'hFFFF_FFFF, 24'h0, 40'h0, 15'h0, 5'd1, 1'b0,
        40'h0, 24'h0, 1'b0},
      '{ROW_DIVISION, mtmc_pkg::OP_APPEND, 32'h0, 24'h0, 40'h0, 15'h7FFF, 5'd1, 1'b0,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_TO_TIME, 32'd50000, 24'h0, 40'h0, 15'h0, 5'd1, 1'b0,
        40'h0, 24'h0, 1'b0},
      '{ROW_REQUEST, mtmc_pkg::OP_BEAT, 32'h0, 24'h0, 40'd1, 15'h0, 5'd1, 1'b0,
        40'h0, 24'h0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   mtmc_req_if req_bus ();
   mtmc_rsp_if rsp_bus ();
   mtmc_csr_if csr_bus ();

   midi_tempo_map_converter_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always #2 clock = ~clock;

   logic [mtmc_pkg::TICK_W-1:0]  map_tick     [mtmc_pkg::TEMPO_ENTRIES];
   logic [mtmc_pkg::TIME_W-1:0]  map_start_us [mtmc_pkg::TEMPO_ENTRIES];
   logic [mtmc_pkg::TEMPO_W-1:0] map_beat_us  [mtmc_pkg::TEMPO_ENTRIES];
   int                           map_count = 0;
   logic [mtmc_pkg::TPQ_W-1:0]   division  = mtmc_pkg::TPQ_RESET;

   map_answer_type map_answers [$];
   int             mismatches   = 0;
   bit             steady       = 1'b0;
   bit             hold_request = 1'b0;

   function automatic logic [mtmc_pkg::TIME_W-1:0] time_at_tick(
         input logic [mtmc_pkg::TICK_W-1:0] tick);
      logic [mtmc_pkg::PROD_W:0]    total;
      logic [mtmc_pkg::TICK_W-1:0]  stop;
      logic [mtmc_pkg::TICK_W-1:0]  span;
      logic [mtmc_pkg::TEMPO_W-1:0] per_tick;
      logic [mtmc_pkg::TPQ_W-1:0]   div;
      bit                           done;
      total = '0;
      done  = 1'b0;
      div   = (division == '0) ? mtmc_pkg::TPQ_W'(1) : division;
      for (int i = 0; i < map_count; i++) begin
         if (!done && map_tick[i] > tick) done = 1'b1;
         if (!done) begin
            per_tick = map_beat_us[i] / mtmc_pkg::TEMPO_W'(div);
            if (i + 1 >= map_count || tick < map_tick[i + 1]) stop = tick;
            else stop = map_tick[i + 1];
            span  = stop - map_tick[i];
            total = total + (mtmc_pkg::PROD_W + 1)'(span) * (mtmc_pkg::PROD_W + 1)'(per_tick);
            if (total > (mtmc_pkg::PROD_W + 1)'(mtmc_pkg::TIME_MAX)) begin
               total = (mtmc_pkg::PROD_W + 1)'(mtmc_pkg::TIME_MAX);
            end
         end
      end
      return total[mtmc_pkg::TIME_W-1:0];
   endfunction

   function automatic logic [mtmc_pkg::TEMPO_W-1:0] beat_at_time(
         input logic [mtmc_pkg::TIME_W-1:0] qtime);
      logic [mtmc_pkg::TEMPO_W-1:0] beat;
      bit                           done;
      beat = mtmc_pkg::DEFAULT_BEAT;
      done = 1'b0;
      for (int i = 0; i < map_count; i++) begin
         if (!done) begin
            if (map_start_us[i] <= qtime) beat = map_beat_us[i];
            else done = 1'b1;
         end
      end
      return beat;
   endfunction

   function automatic map_answer_type apply_to_tempo_map(
         input mtmc_pkg::op_type             op,
         input logic [mtmc_pkg::TICK_W-1:0]  tick,
         input logic [mtmc_pkg::TEMPO_W-1:0] tempo,
         input logic [mtmc_pkg::TIME_W-1:0]  qtime);
      map_answer_type answer;
      answer = '0;
      case (op)
         mtmc_pkg::OP_APPEND: begin
            if (map_count >= mtmc_pkg::TEMPO_ENTRIES) begin
               answer.full = 1'b1;
            end else begin
               map_start_us[map_count] = time_at_tick(tick);
               map_tick[map_count]     = tick;
               map_beat_us[map_count]  = tempo;
               map_count++;
            end
         end
         mtmc_pkg::OP_TO_TIME: answer.time_us = time_at_tick(tick);
         mtmc_pkg::OP_BEAT: answer.beat_us = beat_at_time(qtime);
         default: map_count = 0;
      endcase
      return answer;
   endfunction

   function automatic logic [mtmc_pkg::TEMPO_W-1:0] any_tempo();
      if ($urandom_range(0, 9) == 0) return mtmc_pkg::TEMPO_W'($urandom);
      return mtmc_pkg::TEMPO_W'($urandom_range(100000, 1000000));
   endfunction

   function automatic logic [mtmc_pkg::TIME_W-1:0] any_qtime();
      return {8'($urandom), 32'($urandom)};
   endfunction

   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      while (map_answers.size() != 0) @(posedge clock);
   endtask

   task automatic send_request(input mtmc_pkg::op_type op,
                               input logic [mtmc_pkg::TICK_W-1:0] tick,
                               input logic [mtmc_pkg::TEMPO_W-1:0] tempo,
                               input logic [mtmc_pkg::TIME_W-1:0] qtime,
                               input bit typed, input map_answer_type typed_answer);
      map_answer_type predicted;
      if (!steady && $urandom_range(0, 99) < 23) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while (!steady && $urandom_range(0, 99) < 23);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= op;
      req_bus.tick          <= tick;
      req_bus.tempo_us      <= tempo;
      req_bus.query_time_us <= qtime;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = apply_to_tempo_map(op, tick, tempo, qtime);
      map_answers.push_back(typed ? typed_answer : predicted);
   endtask

   task automatic write_division(input logic [mtmc_pkg::TPQ_W-1:0] value);
      pause_until_drained();
      repeat (4) @(posedge clock);
      csr_bus.valid             <= 1'b1;
      csr_bus.ticks_per_quarter <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      division = value;
   endtask

   task automatic run_phase(input int budget);
      int                          left;
      int                          k;
      logic [mtmc_pkg::TICK_W-1:0] tick;
      left = budget;
      while (left > 0) begin
         if ($urandom_range(0, 99) < 75) begin
            if ($urandom_range(0, 99) < 70) begin
               send_request(mtmc_pkg::OP_CLEAR, $urandom, any_tempo(), any_qtime(), 1'b0, '0);
               left--;
            end
            tick = $urandom_range(0, 2000);
            repeat ($urandom_range(1, 17)) begin
               send_request(mtmc_pkg::OP_APPEND, tick, any_tempo(), any_qtime(), 1'b0, '0);
               if ($urandom_range(0, 9) == 0) tick = tick + $urandom;
               else tick = tick + $urandom_range(1, 5000);
               left--;
            end
            repeat ($urandom_range(2, 10)) begin
               k = $urandom_range(0, map_count - 1);
               case ($urandom_range(0, 4))
                  0: send_request(mtmc_pkg::OP_TO_TIME, map_tick[k] + $urandom_range(0, 2) - 1,
                                  any_tempo(), any_qtime(), 1'b0, '0);
                  1: send_request(mtmc_pkg::OP_TO_TIME, $urandom, any_tempo(), any_qtime(),
                                  1'b0, '0);
                  2: send_request(mtmc_pkg::OP_BEAT, $urandom, any_tempo(),
                                  map_start_us[k] + $urandom_range(0, 2) - 1, 1'b0, '0);
                  3: send_request(mtmc_pkg::OP_BEAT, $urandom, any_tempo(), any_qtime(),
                                  1'b0, '0);
                  default: send_request(mtmc_pkg::OP_TO_TIME, tick + $urandom_range(0, 20000),
                                        any_tempo(), any_qtime(), 1'b0, '0);
               endcase
               left--;
            end
         end else begin
            send_request(mtmc_pkg::op_type'($urandom_range(0, 3)), $urandom,
                         mtmc_pkg::TEMPO_W'($urandom), any_qtime(), 1'b0, '0);
            left--;
         end
      end
   endtask

   task automatic check_answer(input map_answer_type got);
      map_answer_type want;
      if (map_answers.size() == 0) begin
         $display("%0t: unexpected beat, time %h beat %h full %b", $time, got.time_us,
                  got.beat_us, got.full);
         mismatches++;
      end else begin
         want = map_answers.pop_front();
         if (got.time_us !== want.time_us) begin
            $display("%0t: result_time_us expected %h got %h", $time, want.time_us, got.time_us);
            mismatches++;
         end
         if (got.beat_us !== want.beat_us) begin
            $display("%0t: beat_length_us expected %h got %h", $time, want.beat_us, got.beat_us);
            mismatches++;
         end
         if (got.full !== want.full) begin
            $display("%0t: table_full expected %b got %b", $time, want.full, got.full);
            mismatches++;
         end
      end
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            check_answer({rsp_bus.result_time_us, rsp_bus.beat_length_us, rsp_bus.table_full});
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 23);
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("midi_tempo_map_converter_core test failed");
      $finish;
   end

   initial begin
      plan_row_type row;
      req_bus.valid             <= 1'b0;
      req_bus.opcode            <= mtmc_pkg::OP_APPEND;
      req_bus.tick              <= '0;
      req_bus.tempo_us          <= '0;
      req_bus.query_time_us     <= '0;
      csr_bus.valid             <= 1'b0;
      csr_bus.ticks_per_quarter <= mtmc_pkg::TPQ_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         if (row.kind == ROW_DIVISION) begin
            write_division(row.division);
         end else begin
            for (int k = 0; k < row.reps; k++) begin
               send_request(row.op, row.tick + mtmc_pkg::TICK_W'(REP_TICK_STEP * k), row.tempo,
                            row.qtime, row.typed, {row.want_time, row.want_beat, row.want_full});
            end
         end
      end

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: write_division(mtmc_pkg::TPQ_W'(1));
            1: write_division(mtmc_pkg::TPQ_W'(32767));
            2: write_division(mtmc_pkg::TPQ_W'(0));
            3: write_division(mtmc_pkg::TPQ_RESET);
            5: write_division(mtmc_pkg::TPQ_W'(3));
            default: write_division(mtmc_pkg::TPQ_W'($urandom_range(1, 32767)));
         endcase
         steady = (p == 3);
         if (p == 1) hold_request = 1'b1;
         if (p == 2) begin
            run_phase(90);
            pause_until_drained();
            run_phase(90);
         end else begin
            run_phase(180);
         end
      end
      steady = 1'b0;

      pause_until_drained();
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("midi_tempo_map_converter_core test passed");
      end else begin
         $display("midi_tempo_map_converter_core test failed");
      end
      $finish;
   end
endmodule
